// ===== rtl/core/vpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex projection package
// Widths, saturation limits and pipeline payload types shared by the
// vertex transform and perspective divide blocks.
// ----------------------------------------------------------------------------
package vpp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_ROWS  = 4;
    localparam int NUM_LANES = 3;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 66;
    localparam int MAG_W     = 64;
    // Quotient bits produced by the divider; anything wider saturates.
    localparam int QBITS     = 33;
    localparam int PRE_SH    = QBITS - FRAC_BITS;
    localparam int NODIV_W   = MAG_W - FRAC_BITS;
    localparam int DATA_W    = NUM_LANES * COEF_W;
    localparam int USER_W    = 2;

    localparam logic [COEF_W-1:0] POS_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] NEG_MAX = {1'b1, {(COEF_W-1){1'b0}}};

    localparam int USER_WZ  = 0;
    localparam int USER_SAT = 1;

    typedef struct packed {
        logic [MAG_W-1:0]   rem;
        logic [QBITS-1:0]   nbits;
        logic [QBITS-1:0]   quo;
        logic               neg;
        logic               ovf;
        logic [NODIV_W-1:0] nodiv;
    } t_lane;

    typedef struct packed {
        t_lane [NUM_LANES-1:0] lane;
        logic [MAG_W-1:0]      den;
        logic                  wz;
        logic                  wneg;
    } t_div;

endpackage

// ===== rtl/core/vpp_mac.sv =====
// ----------------------------------------------------------------------------
// Vertex projection matrix front end
// Multiplies the vertex by the 4x4 matrix, forms sign and magnitude of each
// row sum and prepares the operands of the divider cells.
// ----------------------------------------------------------------------------
module vpp_mac import vpp_pkg::*; (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [DATA_W-1:0]                i_data,
    input  logic [NUM_REGS-1:0][CFG_W-1:0]   i_mat,
    output logic                             o_valid,
    output t_div                             o_div
);

    logic                     r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid;
    logic signed [COEF_W-1:0] r_a_v [NUM_LANES];
    logic signed [PROD_W-1:0] r_b_p [NUM_ROWS][NUM_LANES];
    logic signed [COEF_W-1:0] r_b_c3 [NUM_ROWS];
    logic signed [SUM_W-1:0]  r_c_s [NUM_ROWS];
    logic [MAG_W-1:0]         r_d_mag [NUM_ROWS];
    logic                     r_d_neg [NUM_ROWS];
    t_div                     r_e_div;

    logic signed [PROD_W-1:0] n_b_p [NUM_ROWS][NUM_LANES];
    logic signed [COEF_W-1:0] n_b_c3 [NUM_ROWS];
    logic signed [SUM_W-1:0]  n_c_s [NUM_ROWS];
    logic [MAG_W-1:0]         n_d_mag [NUM_ROWS];
    logic                     n_d_neg [NUM_ROWS];
    t_div                     n_e_div;

    always_comb begin
        logic [CFG_W-1:0]         reg_w;
        logic signed [COEF_W-1:0] cf;
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                reg_w = i_mat[r*2 + c/2];
                cf = (c % 2 == 1) ? reg_w[CFG_W-1:COEF_W] : reg_w[COEF_W-1:0];
                n_b_p[r][c] = PROD_W'(cf) * PROD_W'(r_a_v[c]);
            end
            reg_w = i_mat[r*2 + 1];
            n_b_c3[r] = reg_w[CFG_W-1:COEF_W];
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            n_c_s[r] = SUM_W'(r_b_p[r][0]) + SUM_W'(r_b_p[r][1]) + SUM_W'(r_b_p[r][2])
                     + (SUM_W'(r_b_c3[r]) <<< FRAC_BITS);
        end
    end

    always_comb begin
        logic [SUM_W-1:0] ngt;
        for (int r = 0; r < NUM_ROWS; r++) begin
            ngt = -r_c_s[r];
            n_d_neg[r] = r_c_s[r][SUM_W-1];
            n_d_mag[r] = n_d_neg[r] ? ngt[MAG_W-1:0] : r_c_s[r][MAG_W-1:0];
        end
    end

    // The quotient fits in QBITS bits only when mag < den * 2^PRE_SH.
    always_comb begin
        logic [MAG_W-1:0] rs;
        n_e_div.den  = r_d_mag[NUM_ROWS-1];
        n_e_div.wz   = (r_d_mag[NUM_ROWS-1] == '0);
        n_e_div.wneg = r_d_neg[NUM_ROWS-1];
        for (int l = 0; l < NUM_LANES; l++) begin
            rs = r_d_mag[l] + (MAG_W'(1) << (FRAC_BITS - 1));
            n_e_div.lane[l].ovf   = {{PRE_SH{1'b0}}, r_d_mag[l]}
                                    >= {r_d_mag[NUM_ROWS-1], {PRE_SH{1'b0}}};
            n_e_div.lane[l].rem   = r_d_mag[l] >> PRE_SH;
            n_e_div.lane[l].nbits = {r_d_mag[l][PRE_SH-1:0], {FRAC_BITS{1'b0}}};
            n_e_div.lane[l].quo   = '0;
            n_e_div.lane[l].neg   = r_d_neg[l];
            n_e_div.lane[l].nodiv = rs[MAG_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                r_a_v[c] <= i_data[c*COEF_W +: COEF_W];
            end
            r_b_p   <= n_b_p;
            r_b_c3  <= n_b_c3;
            r_c_s   <= n_c_s;
            r_d_mag <= n_d_mag;
            r_d_neg <= n_d_neg;
            r_e_div <= n_e_div;
        end
    end

    assign o_valid = r_e_valid;
    assign o_div   = r_e_div;

endmodule

// ===== rtl/core/vpp_div_cell.sv =====
// ----------------------------------------------------------------------------
// Vertex projection divider cell
// One restoring division step for all three lanes, registered.
// ----------------------------------------------------------------------------
module vpp_div_cell import vpp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_d,
    output logic o_valid,
    output t_div o_d
);

    logic r_valid;
    t_div r_d;
    t_div n_d;

    always_comb begin
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           ge;
        n_d = i_d;
        for (int l = 0; l < NUM_LANES; l++) begin
            trial = {i_d.lane[l].rem, i_d.lane[l].nbits[QBITS-1]};
            diff  = trial - {1'b0, i_d.den};
            ge    = trial >= {1'b0, i_d.den};
            n_d.lane[l].rem   = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            n_d.lane[l].nbits = i_d.lane[l].nbits << 1;
            n_d.lane[l].quo   = {i_d.lane[l].quo[QBITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

// ===== rtl/core/vpp_post.sv =====
// ----------------------------------------------------------------------------
// Vertex projection result stage
// Rounds the quotient, picks the undivided value when w is zero, applies the
// sign and saturates into the output register.
// ----------------------------------------------------------------------------
module vpp_post import vpp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_div              i_d,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    output logic [USER_W-1:0] o_user
);

    logic               r_p_valid;
    logic [NODIV_W-1:0] r_p_q [NUM_LANES];
    logic               r_p_neg [NUM_LANES];
    logic               r_p_wz;
    logic               r_o_valid;
    logic [DATA_W-1:0]  r_o_data;
    logic [USER_W-1:0]  r_o_user;

    logic [NODIV_W-1:0] n_p_q [NUM_LANES];
    logic               n_p_neg [NUM_LANES];
    logic [DATA_W-1:0]  n_o_data;
    logic [USER_W-1:0]  n_o_user;

    always_comb begin
        logic               rnd;
        logic [NODIV_W-1:0] qd;
        for (int l = 0; l < NUM_LANES; l++) begin
            rnd = {i_d.lane[l].rem, 1'b0} >= {1'b0, i_d.den};
            qd  = NODIV_W'(i_d.lane[l].quo) + NODIV_W'(rnd);
            if (i_d.wz) begin
                n_p_q[l]   = i_d.lane[l].nodiv;
                n_p_neg[l] = i_d.lane[l].neg;
            end else begin
                n_p_q[l]   = i_d.lane[l].ovf ? '1 : qd;
                n_p_neg[l] = i_d.lane[l].neg ^ i_d.wneg;
            end
            if (n_p_q[l] == '0) begin
                n_p_neg[l] = 1'b0;
            end
        end
    end

    always_comb begin
        logic sat;
        sat = 1'b0;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (!r_p_neg[l]) begin
                if (r_p_q[l] > NODIV_W'(POS_MAX)) begin
                    n_o_data[l*COEF_W +: COEF_W] = POS_MAX;
                    sat = 1'b1;
                end else begin
                    n_o_data[l*COEF_W +: COEF_W] = r_p_q[l][COEF_W-1:0];
                end
            end else begin
                if (r_p_q[l] > NODIV_W'(NEG_MAX)) begin
                    n_o_data[l*COEF_W +: COEF_W] = NEG_MAX;
                    sat = 1'b1;
                end else begin
                    n_o_data[l*COEF_W +: COEF_W] = COEF_W'(0) - r_p_q[l][COEF_W-1:0];
                end
            end
        end
        n_o_user           = '0;
        n_o_user[USER_WZ]  = r_p_wz;
        n_o_user[USER_SAT] = sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_q    <= n_p_q;
            r_p_neg  <= n_p_neg;
            r_p_wz   <= i_d.wz;
            r_o_data <= n_o_data;
            r_o_user <= n_o_user;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_user  = r_o_user;

endmodule

// ===== rtl/core/vertex_perspective_project.sv =====
// ----------------------------------------------------------------------------
// Vertex perspective projection
// 4x4 homogeneous vertex transform followed by a rounded perspective divide.
// ----------------------------------------------------------------------------
// One vertex is accepted on every clock and one projected vertex leaves on
// every clock while no result is stalled. The front end registers the vertex,
// the products, the row sums, the magnitudes and the divider operands; each of
// the 33 cells of the divider chain then works out one quotient bit for x, y
// and z together, followed by the rounding and output registers. While a result
// waits at the output the whole pipeline holds and s_axis_tready is low. The
// matrix registers must only be written while no vertex is in flight.
module vertex_perspective_project import vpp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,  // vx, vy, vz
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,  // px, py, pz
    output logic [USER_W-1:0]    m_axis_tuser   // w_was_zero, saturated
);

    logic [NUM_REGS-1:0][CFG_W-1:0] r_mat;
    logic                           w_en;
    logic                           w_valid [QBITS+1];
    t_div                           w_div [QBITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '0;
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign w_en          = !(m_axis_tvalid && !m_axis_tready);
    assign s_axis_tready = w_en;

    vpp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_mat   (r_mat),
        .o_valid (w_valid[0]),
        .o_div   (w_div[0])
    );

    for (genvar g = 0; g < QBITS; g++) begin : g_cell
        vpp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_d     (w_div[g]),
            .o_valid (w_valid[g+1]),
            .o_d     (w_div[g+1])
        );
    end

    vpp_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[QBITS]),
        .i_d     (w_div[QBITS]),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

endmodule

// ===== rtl/core/vpp_checker.sv =====
// ----------------------------------------------------------------------------
// Vertex projection port checker
// Watches the ports of the projection block for handshake and flag errors.
// ----------------------------------------------------------------------------
module vpp_checker import vpp_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [CFG_W-1:0]     i_cfg_data,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [DATA_W-1:0]    s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [DATA_W-1:0]    m_axis_tdata,
    input logic [USER_W-1:0]    m_axis_tuser
);

    // A stalled transaction keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // The input side is held back exactly when a result is stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
        else $error("input ready does not follow output stall");

    // The pipeline is empty straight after reset.
    a_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result shown right after reset");

    // A saturation flag needs at least one clamped coordinate.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_SAT] |->
        m_axis_tdata[31:0] == POS_MAX || m_axis_tdata[31:0] == NEG_MAX ||
        m_axis_tdata[63:32] == POS_MAX || m_axis_tdata[63:32] == NEG_MAX ||
        m_axis_tdata[95:64] == POS_MAX || m_axis_tdata[95:64] == NEG_MAX)
        else $error("saturation flag without a clamped value");

endmodule

bind vertex_perspective_project vpp_checker u_vpp_checker (.*);
